@@ design/i2wt_pkg.sv @@
`timescale 1ns / 1ps
package i2wt_pkg;

  localparam int unsigned ValueW  = 31;
  localparam int unsigned CodeW   = 5;
  localparam int unsigned DigitsN = 12;
  localparam int unsigned BcdW    = 4 * DigitsN;
  localparam int unsigned StepW   = 3;
  localparam int unsigned CntW    = 5;

  localparam logic [CodeW-1:0] CodeZero     = 5'd0;
  localparam logic [CodeW-1:0] CodeTen      = 5'd10;
  localparam logic [CodeW-1:0] CodeTensOfs  = 5'd18;
  localparam logic [CodeW-1:0] CodeHundred  = 5'd28;
  localparam logic [CodeW-1:0] CodeBillion  = 5'd31;

  typedef enum logic [2:0] {
    EmitNone,
    EmitHund,
    EmitHundWord,
    EmitTens,
    EmitOnes,
    EmitScale
  } emit_e;

  typedef enum logic [1:0] {
    JmpNever,
    JmpConvBusy,
    JmpGrpMore
  } jmp_e;

  typedef struct packed {
    emit_e            emit;
    logic             dab;
    logic             grp_inc;
    logic             fin;
    jmp_e             jmp;
    logic [StepW-1:0] tgt;
  } ctrl_t;

  localparam logic [StepW-1:0] StConv  = 3'd0;
  localparam logic [StepW-1:0] StHund  = 3'd1;
  localparam logic [StepW-1:0] StHWord = 3'd2;
  localparam logic [StepW-1:0] StTens  = 3'd3;
  localparam logic [StepW-1:0] StOnes  = 3'd4;
  localparam logic [StepW-1:0] StScale = 3'd5;
  localparam logic [StepW-1:0] StFin   = 3'd6;

  // control store
  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t w;
    w = '{emit: EmitNone, dab: 1'b0, grp_inc: 1'b0, fin: 1'b0, jmp: JmpNever, tgt: StConv};
    case (step)
      StConv: begin
        w.dab = 1'b1;
        w.jmp = JmpConvBusy;
        w.tgt = StConv;
      end
      StHund:  w.emit = EmitHund;
      StHWord: w.emit = EmitHundWord;
      StTens:  w.emit = EmitTens;
      StOnes:  w.emit = EmitOnes;
      StScale: begin
        w.emit    = EmitScale;
        w.grp_inc = 1'b1;
        w.jmp     = JmpGrpMore;
        w.tgt     = StHund;
      end
      default: w.fin = 1'b1;
    endcase
    return w;
  endfunction

endpackage

@@ design/integer_to_word_tokens.sv @@
`timescale 1ns / 1ps
// Speaks a 31-bit non-negative value as a stream of English word-token codes, most
// significant first, one token per strobe on valid_o, the final one flagged by last_word_o.
// A request is taken when start_i is high and busy_o low. The value is first converted to
// decimal by a shift-and-add-3 pass over every value bit, then a seven-step microprogram
// walks the four digit groups (five steps per group). Strobes are not evenly spaced, since
// zero groups emit nothing and each token is held back one emit step to learn whether it
// is the last. Tokens cannot be held off: the receiver must take each one in the cycle it
// is shown. busy_o falls in the cycle that shows the last token, so the next request may
// be given then.
module integer_to_word_tokens
  import i2wt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [ValueW-1:0] value_i,
  output logic              valid_o,
  output logic [CodeW-1:0]  word_code_o,
  output logic              last_word_o
);

  logic              busy_q;
  logic [StepW-1:0]  step_q, step_d;
  logic [CntW-1:0]   cnt_q;
  logic [1:0]        grp_q;
  logic [ValueW-1:0] bin_q;
  logic [BcdW-1:0]   bcd_q, bcd_adj;
  logic              pend_vld_q;
  logic [CodeW-1:0]  pend_q;
  logic              valid_q, last_q;
  logic [CodeW-1:0]  code_q;
  logic              grp_nz_q;

  ctrl_t       cw;
  logic [11:0] gdig;
  logic [3:0]  hd, td, od;
  logic        emit_v;
  logic [CodeW-1:0] emit_code;
  logic        jump;
  logic        accept;

  assign accept = start_i && !busy_q;
  assign cw     = ucode(step_q);

  always_comb begin
    for (int i = 0; i < DigitsN; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                   : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    case (grp_q)
      2'd0:    gdig = bcd_q[47:36];
      2'd1:    gdig = bcd_q[35:24];
      2'd2:    gdig = bcd_q[23:12];
      default: gdig = bcd_q[11:0];
    endcase
  end

  assign hd = gdig[11:8];
  assign td = gdig[7:4];
  assign od = gdig[3:0];

  always_comb begin
    emit_v    = 1'b0;
    emit_code = CodeZero;
    case (cw.emit)
      EmitHund: begin
        emit_v    = (hd != 4'd0);
        emit_code = {1'b0, hd};
      end
      EmitHundWord: begin
        emit_v    = (hd != 4'd0);
        emit_code = CodeHundred;
      end
      EmitTens: begin
        emit_v    = (td >= 4'd2);
        emit_code = CodeTensOfs + {1'b0, td};
      end
      EmitOnes: begin
        if (td == 4'd1) begin
          emit_v    = 1'b1;
          emit_code = CodeTen + {1'b0, od};
        end else begin
          emit_v    = (od != 4'd0);
          emit_code = {1'b0, od};
        end
      end
      EmitScale: begin
        emit_v    = (gdig != 12'd0) && (grp_q != 2'd3);
        emit_code = CodeBillion - {3'd0, grp_q};
      end
      default: begin
        emit_v    = 1'b0;
        emit_code = CodeZero;
      end
    endcase
  end

  always_comb begin
    case (cw.jmp)
      JmpConvBusy: jump = (cnt_q != '0);
      JmpGrpMore:  jump = (grp_q != 2'd3);
      default:     jump = 1'b0;
    endcase
    step_d = jump ? cw.tgt : step_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      step_q     <= StConv;
      pend_vld_q <= 1'b0;
      valid_q    <= 1'b0;
      grp_q      <= 2'd0;
    end else begin
      valid_q <= 1'b0;
      if (accept) begin
        busy_q     <= 1'b1;
        step_q     <= StConv;
        pend_vld_q <= 1'b0;
        grp_q      <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_d;
        if (cw.grp_inc) begin
          grp_q <= grp_q + 2'd1;
        end
        if (emit_v) begin
          pend_vld_q <= 1'b1;
          valid_q    <= pend_vld_q;
        end
        if (cw.fin) begin
          busy_q     <= 1'b0;
          valid_q    <= 1'b1;
          pend_vld_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bin_q <= value_i;
      bcd_q <= '0;
      cnt_q <= CntW'(ValueW - 1);
    end else if (busy_q) begin
      if (cw.dab) begin
        bcd_q <= {bcd_adj[BcdW-2:0], bin_q[ValueW-1]};
        bin_q <= {bin_q[ValueW-2:0], 1'b0};
        cnt_q <= cnt_q - 5'd1;
      end
      if (emit_v) begin
        pend_q <= emit_code;
        code_q <= pend_q;
        last_q <= 1'b0;
      end
      if (cw.fin) begin
        code_q <= pend_vld_q ? pend_q : CodeZero;
        last_q <= 1'b1;
      end
    end
  end

  assign busy_o      = busy_q;
  assign valid_o     = valid_q;
  assign word_code_o = code_q;
  assign last_word_o = last_q;

`ifndef SYNTHESIS
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_word_o |-> busy_o)
    else $error("non-final token shown while idle");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_word_o |-> !busy_o)
    else $error("final token shown while still busy");
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !valid_o)
    else $error("token shown straight after a request");
  a_fin_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> valid_o && last_word_o)
    else $error("request ended without final token");
`endif

endmodule

@@ tb/integer_to_word_tokens_test.sv @@
`timescale 1ns / 1ps
module integer_to_word_tokens_test;
  import i2wt_pkg::*;

  localparam logic [CodeW-1:0] CodeThousand = CodeBillion - 5'd2;
  localparam int unsigned      ValueMax     = 32'h7FFF_FFFF;

  typedef struct {
    logic [CodeW-1:0] code;
    logic             last;
  } word_t;

  typedef struct {
    logic [ValueW-1:0] value;
    bit                drain;
  } request_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [ValueW-1:0] value_i = '0;
  logic              busy_o;
  logic              valid_o;
  logic [CodeW-1:0]  word_code_o;
  logic              last_word_o;

  request_t    request_q[$];
  word_t       spoken_q[$];
  int unsigned sent_cnt = 0;
  bit          mismatch_seen = 1'b0;

  integer_to_word_tokens i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .word_code_o(word_code_o),
    .last_word_o(last_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void push_word(input logic [CodeW-1:0] code);
    word_t w;
    w.code = code;
    w.last = 1'b0;
    spoken_q.push_back(w);
  endfunction

  // expected token stream for one value, three digits per group
  function automatic void spell_value(input logic [ValueW-1:0] v);
    int unsigned scale_div[4];
    int unsigned n;
    int unsigned grp;
    int unsigned hund;
    int unsigned rest;
    scale_div = '{1, 1000, 1000000, 1000000000};
    n = v;
    if (n == 0) begin
      push_word(CodeZero);
    end else begin
      for (int g = 3; g >= 0; g--) begin
        grp = (n / scale_div[g]) % 1000;
        if (grp != 0) begin
          hund = grp / 100;
          rest = grp % 100;
          if (hund != 0) begin
            push_word(CodeW'(hund));
            push_word(CodeHundred);
          end
          if (rest >= 20) begin
            push_word(CodeTensOfs + CodeW'(rest / 10));
            rest = rest % 10;
          end
          if (rest >= 10) begin
            push_word(CodeTen + CodeW'(rest - 10));
          end else if (rest != 0) begin
            push_word(CodeW'(rest));
          end
          if (g != 0) begin
            push_word(CodeThousand + CodeW'(g - 1));
          end
        end
      end
    end
    spoken_q[spoken_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void queue_value(input int unsigned v, input bit drain);
    request_t r;
    r.value = ValueW'(v);
    r.drain = drain;
    request_q.push_back(r);
  endfunction

  // random value built group by group so zero groups, teens and round tens turn up often
  function automatic int unsigned grouped_value();
    int unsigned grp[3];
    int unsigned top;
    int unsigned low;
    for (int g = 0; g < 3; g++) begin
      case ($urandom_range(5))
        0, 1: grp[g] = 0;
        2: grp[g] = 100 * $urandom_range(9) + 10 + $urandom_range(9);
        3: grp[g] = 100 * $urandom_range(9) + 10 * $urandom_range(9);
        default: grp[g] = $urandom_range(999);
      endcase
    end
    low = grp[2] * 1000000 + grp[1] * 1000 + grp[0];
    top = $urandom_range(2);
    if (top == 2 && low > ValueMax - 2000000000) begin
      top = 1;
    end
    return top * 1000000000 + low;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      value_i <= '0;
    end else begin : drive
      bit       taken;
      bit       hold;
      bit       idle;
      request_t r;
      taken = start_i && !busy_o;
      if (taken) begin
        spell_value(value_i);
        sent_cnt++;
      end
      if (!start_i || taken) begin
        idle = !(sent_cnt >= 50 && sent_cnt < 90) && ($urandom_range(99) < 12);
        hold = request_q.size() != 0 && request_q[0].drain && spoken_q.size() != 0;
        if (request_q.size() != 0 && !idle && !hold) begin
          r = request_q.pop_front();
          start_i <= 1'b1;
          value_i <= r.value;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin : watch
      word_t w;
      if (spoken_q.size() == 0) begin
        $error("unexpected token: word_code %0d last_word %0b", word_code_o, last_word_o);
        mismatch_seen = 1'b1;
      end else begin
        w = spoken_q.pop_front();
        if (word_code_o !== w.code) begin
          $error("word_code expected %0d actual %0d", w.code, word_code_o);
          mismatch_seen = 1'b1;
        end
        if (last_word_o !== w.last) begin
          $error("last_word expected %0b actual %0b", w.last, last_word_o);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  initial begin
    queue_value(0, 1'b0);
    queue_value(1, 1'b0);
    queue_value(9, 1'b0);
    queue_value(10, 1'b0);
    queue_value(15, 1'b0);
    queue_value(19, 1'b0);
    queue_value(20, 1'b0);
    queue_value(21, 1'b0);
    queue_value(99, 1'b0);
    queue_value(100, 1'b1);
    queue_value(101, 1'b0);
    queue_value(110, 1'b0);
    queue_value(999, 1'b0);
    queue_value(1000, 1'b0);
    queue_value(1019, 1'b0);
    queue_value(1000000, 1'b0);
    queue_value(1000000000, 1'b0);
    queue_value(2000000000, 1'b0);
    queue_value(1001001, 1'b0);
    queue_value(900000090, 1'b0);
    queue_value(ValueMax, 1'b1);
    queue_value(ValueMax, 1'b0);
    queue_value(0, 1'b0);
    queue_value(32'h5555_5555 & ValueMax, 1'b0);
    queue_value(32'h2AAA_AAAA, 1'b0);
    for (int i = 0; i < 105; i++) begin
      case ($urandom_range(3))
        0, 1: queue_value(grouped_value(), $urandom_range(99) < 3);
        2: queue_value($urandom & ValueMax, $urandom_range(99) < 3);
        default: queue_value($urandom_range(999), $urandom_range(99) < 3);
      endcase
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (request_q.size() != 0 || start_i || spoken_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (60) @(posedge clk_i);
    if (!mismatch_seen) begin
      $display("[integer_to_word_tokens] OK");
    end else begin
      $display("[integer_to_word_tokens] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[integer_to_word_tokens] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
design/i2wt_pkg.sv
design/integer_to_word_tokens.sv
tb/integer_to_word_tokens_test.sv
